// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps

package dq_pkg;

    typedef logic [1:0] t_action;

    localparam t_action ACT_NONE   = 2'd0;
    localparam t_action ACT_PUSH_R = 2'd1;
    localparam t_action ACT_POP_L  = 2'd2;
    localparam t_action ACT_POP_R  = 2'd3;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

endpackage

// ----- hw/rtl/dq_ram.sv -----
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// A transfer parks its result in pending registers while the wait state refreshes
// the left or right peek value from the store's single registered read port. No new
// item is taken until the result moves to the output register; a new item is taken
// while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the queue; store contents are not cleared.
module double_ended_queue #(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  dq_pkg::t_action            i_action,
    input  logic [dq_pkg::DATA_W-1:0]  i_item_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dq_pkg::DATA_W-1:0]  o_popped_item,
    output logic                       o_pop_ok,
    output logic [dq_pkg::DATA_W-1:0]  o_left_item,
    output logic [dq_pkg::DATA_W-1:0]  o_right_item,
    output logic                       o_is_empty,
    output logic [dq_pkg::OCC_W-1:0]   o_occupancy,
    output logic                       o_overflow
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
        if (s >= (AW+1)'(CAPACITY)) begin
            return AW'(s - (AW+1)'(CAPACITY));
        end else begin
            return s[AW-1:0];
        end
    endfunction

    logic                  r_state, n_state;
    logic [AW-1:0]         r_left_ptr, n_left_ptr;
    logic [CW-1:0]         r_count, n_count;
    logic [ITEM_WIDTH-1:0] r_left_val, n_left_val;
    logic [ITEM_WIDTH-1:0] r_right_val, n_right_val;
    logic                  r_fix_left, n_fix_left;
    logic                  r_fix_right, n_fix_right;
    logic [ITEM_WIDTH-1:0] r_pend_popped, n_pend_popped;
    logic                  r_pend_pop_ok, n_pend_pop_ok;
    logic                  r_pend_ovf, n_pend_ovf;
    logic                  r_out_valid, n_out_valid;

    logic [dq_pkg::DATA_W-1:0] r_out_popped, r_out_left, r_out_right;
    logic                      r_out_pop_ok, r_out_empty, r_out_ovf;
    logic [dq_pkg::OCC_W-1:0]  r_out_occ;

    logic                  in_xfer, load_out, q_empty, q_full;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr, push_slot, next_left, pop_r_slot;
    logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata, wr_value, peek_left, peek_right;

    dq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign load_out = (r_state == ST_WAIT) && (!r_out_valid || i_ready);
    assign q_empty  = (r_count == '0);
    assign q_full   = (r_count == CW'(CAPACITY));
    assign wr_value = ITEM_WIDTH'(i_item_in);

    assign push_slot  = wrap_slot({1'b0, r_left_ptr} + (AW+1)'(r_count));
    assign next_left  = wrap_slot({1'b0, r_left_ptr} + (AW+1)'(1));
    assign pop_r_slot = wrap_slot({1'b0, r_left_ptr} + (AW+1)'(r_count - CW'(2)));

    // The read issued at the transfer returns the new neighbor of the end that was popped.
    assign peek_left  = r_fix_left  ? ram_rdata : r_left_val;
    assign peek_right = r_fix_right ? ram_rdata : r_right_val;

    always_comb begin
        n_state       = r_state;
        n_left_ptr    = r_left_ptr;
        n_count       = r_count;
        n_left_val    = r_left_val;
        n_right_val   = r_right_val;
        n_fix_left    = r_fix_left;
        n_fix_right   = r_fix_right;
        n_pend_popped = r_pend_popped;
        n_pend_pop_ok = r_pend_pop_ok;
        n_pend_ovf    = r_pend_ovf;
        n_out_valid   = r_out_valid && !i_ready;
        ram_we        = 1'b0;
        ram_waddr     = push_slot;
        ram_wdata     = wr_value;
        ram_re        = 1'b0;
        ram_raddr     = next_left;

        if (in_xfer) begin
            n_state       = ST_WAIT;
            n_fix_left    = 1'b0;
            n_fix_right   = 1'b0;
            n_pend_popped = '0;
            n_pend_pop_ok = 1'b0;
            n_pend_ovf    = 1'b0;
            unique case (i_action)
                dq_pkg::ACT_NONE: begin
                end
                dq_pkg::ACT_PUSH_R: begin
                    if (q_full) begin
                        n_pend_ovf = 1'b1;
                    end else begin
                        ram_we      = 1'b1;
                        n_right_val = wr_value;
                        if (q_empty) begin
                            n_left_val = wr_value;
                        end
                        n_count = r_count + CW'(1);
                    end
                end
                dq_pkg::ACT_POP_L: begin
                    if (!q_empty) begin
                        n_pend_popped = r_left_val;
                        n_pend_pop_ok = 1'b1;
                        n_left_ptr    = next_left;
                        n_count       = r_count - CW'(1);
                        if (r_count != CW'(1)) begin
                            ram_re     = 1'b1;
                            ram_raddr  = next_left;
                            n_fix_left = 1'b1;
                        end
                    end
                end
                dq_pkg::ACT_POP_R: begin
                    if (!q_empty) begin
                        n_pend_popped = r_right_val;
                        n_pend_pop_ok = 1'b1;
                        n_count       = r_count - CW'(1);
                        if (r_count != CW'(1)) begin
                            ram_re      = 1'b1;
                            ram_raddr   = pop_r_slot;
                            n_fix_right = 1'b1;
                        end
                    end
                end
            endcase
        end else if (load_out) begin
            n_state     = ST_IDLE;
            n_left_val  = peek_left;
            n_right_val = peek_right;
            n_fix_left  = 1'b0;
            n_fix_right = 1'b0;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left_ptr  <= '0;
            r_count     <= '0;
            r_fix_left  <= 1'b0;
            r_fix_right <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left_ptr  <= n_left_ptr;
            r_count     <= n_count;
            r_fix_left  <= n_fix_left;
            r_fix_right <= n_fix_right;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left_val    <= n_left_val;
        r_right_val   <= n_right_val;
        r_pend_popped <= n_pend_popped;
        r_pend_pop_ok <= n_pend_pop_ok;
        r_pend_ovf    <= n_pend_ovf;
        if (load_out) begin
            r_out_popped <= dq_pkg::DATA_W'(r_pend_popped);
            r_out_pop_ok <= r_pend_pop_ok;
            r_out_left   <= q_empty ? '0 : dq_pkg::DATA_W'(peek_left);
            r_out_right  <= q_empty ? '0 : dq_pkg::DATA_W'(peek_right);
            r_out_empty  <= q_empty;
            r_out_occ    <= dq_pkg::OCC_W'(r_count);
            r_out_ovf    <= r_pend_ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_popped_item = r_out_popped;
    assign o_pop_ok      = r_out_pop_ok;
    assign o_left_item   = r_out_left;
    assign o_right_item  = r_out_right;
    assign o_is_empty    = r_out_empty;
    assign o_occupancy   = r_out_occ;
    assign o_overflow    = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy exceeds capacity");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in the same cycle");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == dq_pkg::ACT_POP_L && !q_empty)
        |=> (r_count == $past(r_count) - CW'(1)) && (r_state == ST_WAIT))
        else $error("left pop did not shrink the queue");

    a_ok_excl_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_pop_ok && r_out_ovf))
        else $error("pop success and overflow reported together");

endmodule

// ----- sim/double_ended_queue_tb.sv -----
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int RING_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic [dq_pkg::DATA_W-1:0] popped;
        logic                      pop_ok;
        logic [dq_pkg::DATA_W-1:0] left;
        logic [dq_pkg::DATA_W-1:0] right;
        logic                      empty;
        logic [dq_pkg::OCC_W-1:0]  occ;
        logic                      ovf;
    } t_deque_result;

    typedef struct {
        dq_pkg::t_action           act;
        logic [dq_pkg::DATA_W-1:0] val;
        bit                        typed;
        t_deque_result             res;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    dq_pkg::t_action           i_action = dq_pkg::ACT_NONE;
    logic [dq_pkg::DATA_W-1:0] i_item_in = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [dq_pkg::DATA_W-1:0] o_popped_item;
    logic                      o_pop_ok;
    logic [dq_pkg::DATA_W-1:0] o_left_item;
    logic [dq_pkg::DATA_W-1:0] o_right_item;
    logic                      o_is_empty;
    logic [dq_pkg::OCC_W-1:0]  o_occupancy;
    logic                      o_overflow;

    // Shadow copy of the ring buffer used for prediction.
    logic [dq_pkg::DATA_W-1:0] ring_mem [RING_DEPTH];
    int                        ring_head = 0;
    int                        ring_count = 0;

    t_deque_result     pending_results [$];
    t_stim_row         directed_rows [$];
    t_deque_result     got;

    int  fail_count = 0;
    int  idle_cycles = 0;
    int  n_push = 0;
    int  n_dropped = 0;
    int  n_pop = 0;
    int  n_empty_pop = 0;
    int  peak_occ = 0;
    int  stall_cycles = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  steady = 1'b0;

    double_ended_queue uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_item_in    (i_item_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_popped_item(o_popped_item),
        .o_pop_ok     (o_pop_ok),
        .o_left_item  (o_left_item),
        .o_right_item (o_right_item),
        .o_is_empty   (o_is_empty),
        .o_occupancy  (o_occupancy),
        .o_overflow   (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int ring_slot(int offset);
        return (ring_head + offset) % RING_DEPTH;
    endfunction

    function automatic t_deque_result deque_step(dq_pkg::t_action act,
                                                 logic [dq_pkg::DATA_W-1:0] val);
        t_deque_result r;
        r = '{default: '0};
        case (act)
            dq_pkg::ACT_PUSH_R: begin
                if (ring_count >= RING_DEPTH) begin
                    r.ovf = 1'b1;
                end else begin
                    ring_mem[ring_slot(ring_count)] = val;
                    ring_count++;
                end
            end
            dq_pkg::ACT_POP_L: begin
                if (ring_count != 0) begin
                    r.popped = ring_mem[ring_slot(0)];
                    r.pop_ok = 1'b1;
                    ring_head = ring_slot(1);
                    ring_count--;
                end
            end
            dq_pkg::ACT_POP_R: begin
                if (ring_count != 0) begin
                    r.popped = ring_mem[ring_slot(ring_count - 1)];
                    r.pop_ok = 1'b1;
                    ring_count--;
                end
            end
            default: ;
        endcase
        if (ring_count != 0) begin
            r.left  = ring_mem[ring_slot(0)];
            r.right = ring_mem[ring_slot(ring_count - 1)];
        end
        r.empty = (ring_count == 0);
        r.occ   = ring_count[dq_pkg::OCC_W-1:0];
        return r;
    endfunction

    function automatic void add_row(dq_pkg::t_action act, logic [dq_pkg::DATA_W-1:0] val,
                                    bit typed, logic [dq_pkg::DATA_W-1:0] popped,
                                    logic pop_ok, logic [dq_pkg::DATA_W-1:0] left,
                                    logic [dq_pkg::DATA_W-1:0] right, logic empty,
                                    logic [dq_pkg::OCC_W-1:0] occ, logic ovf);
        t_stim_row row;
        row.act        = act;
        row.val        = val;
        row.typed      = typed;
        row.res.popped = popped;
        row.res.pop_ok = pop_ok;
        row.res.left   = left;
        row.res.right  = right;
        row.res.empty  = empty;
        row.res.occ    = occ;
        row.res.ovf    = ovf;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(dq_pkg::DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(string name, logic [dq_pkg::DATA_W-1:0] exp_v,
                               logic [dq_pkg::DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Offers one item, waits for its transfer, then records what the block should answer.
    task automatic send_item(dq_pkg::t_action act, logic [dq_pkg::DATA_W-1:0] val,
                             bit typed, t_deque_result typed_res);
        t_deque_result r;
        if (!steady) begin
            while ($urandom_range(99) < 33) begin
                i_valid   <= 1'b0;
                i_item_in <= $urandom;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_item_in <= val;
        @(posedge i_clk);
        while (!o_ready) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        r = deque_step(act, val);
        if (typed)
            r = typed_res;
        if (act == dq_pkg::ACT_PUSH_R) begin
            if (r.ovf)
                n_dropped++;
            else
                n_push++;
        end else if (act != dq_pkg::ACT_NONE) begin
            if (r.pop_ok)
                n_pop++;
            else
                n_empty_pop++;
        end
        if (ring_count > peak_occ)
            peak_occ = ring_count;
        pending_results.insert(pending_results.size(), r);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // Keep the output blocked long enough for the input side to back up.
                i_ready   <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with no expected result pending", $time);
            end else begin
                got = pending_results.pop_front();
                check_field("popped_item", got.popped, o_popped_item);
                check_field("pop_ok", got.pop_ok, o_pop_ok);
                check_field("left_item", got.left, o_left_item);
                check_field("right_item", got.right, o_right_item);
                check_field("is_empty", got.empty, o_is_empty);
                check_field("occupancy", got.occ, o_occupancy);
                check_field("overflow", got.ovf, o_overflow);
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_deque_result   r;
        dq_pkg::t_action act;
        int              mode;
        int              pick;

        // Empty queue: the no-op and both pops report zeros and the empty flag; pushes and pops follow.
        add_row(dq_pkg::ACT_NONE,   32'h0,        1, 32'h0, 0, 32'h0, 32'h0, 1, 5'd0, 0);
        add_row(dq_pkg::ACT_POP_L,  32'hFFFFFFFF, 1, 32'h0, 0, 32'h0, 32'h0, 1, 5'd0, 0);
        add_row(dq_pkg::ACT_POP_R,  32'hFFFFFFFF, 1, 32'h0, 0, 32'h0, 32'h0, 1, 5'd0, 0);
        add_row(dq_pkg::ACT_PUSH_R, 32'hFFFFFFFF, 1, 32'h0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                0, 5'd1, 0);
        add_row(dq_pkg::ACT_PUSH_R, 32'h0,        1, 32'h0, 0, 32'hFFFFFFFF, 32'h0,
                0, 5'd2, 0);
        add_row(dq_pkg::ACT_NONE,   32'hAAAAAAAA, 1, 32'h0, 0, 32'hFFFFFFFF, 32'h0,
                0, 5'd2, 0);
        add_row(dq_pkg::ACT_POP_R,  32'h55555555, 1, 32'h0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF,
                0, 5'd1, 0);
        add_row(dq_pkg::ACT_POP_L,  32'h0,        1, 32'hFFFFFFFF, 1, 32'h0, 32'h0,
                1, 5'd0, 0);
        // The left pointer now sits at one, so filling up wraps around the ring.
        for (int k = 0; k < RING_DEPTH; k++)
            add_row(dq_pkg::ACT_PUSH_R, 32'hC0DE0000 + k, 0, '0, 0, '0, '0, 0, '0, 0);
        add_row(dq_pkg::ACT_PUSH_R, 32'h12345678, 1, 32'h0, 0, 32'hC0DE0000, 32'hC0DE000F,
                0, 5'd16, 1);
        add_row(dq_pkg::ACT_POP_L,  32'h0,        1, 32'hC0DE0000, 1, 32'hC0DE0001,
                32'hC0DE000F, 0, 5'd15, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].act, directed_rows[k].val, directed_rows[k].typed,
                      directed_rows[k].res);

        r    = '{default: '0};
        mode = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // Alternate between filling, draining and mixed traffic in blocks.
            if (k % 50 == 0)
                mode = $urandom_range(2);
            if (k == 100)
                hold_req = 1'b1;
            steady = (k >= 250 && k < 400);
            pick = $urandom_range(99);
            case (mode)
                0: act = (pick < 70) ? dq_pkg::ACT_PUSH_R : (pick < 80) ? dq_pkg::ACT_POP_L :
                         (pick < 90) ? dq_pkg::ACT_POP_R : dq_pkg::ACT_NONE;
                1: act = (pick < 15) ? dq_pkg::ACT_PUSH_R : (pick < 50) ? dq_pkg::ACT_POP_L :
                         (pick < 85) ? dq_pkg::ACT_POP_R : dq_pkg::ACT_NONE;
                default: act = (pick < 35) ? dq_pkg::ACT_PUSH_R :
                               (pick < 60) ? dq_pkg::ACT_POP_L :
                               (pick < 85) ? dq_pkg::ACT_POP_R : dq_pkg::ACT_NONE;
            endcase
            send_item(act, pick_value(), 0, r);
        end
        steady  = 1'b0;
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d pushes, %0d dropped on full, %0d pops, %0d pops on empty.",
                 directed_rows.size() + RANDOM_ITEMS, n_push, n_dropped, n_pop, n_empty_pop);
        $display("Peak occupancy %0d, input held back for %0d cycles.", peak_occ, stall_cycles);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/double_ended_queue.sv
sim/double_ended_queue_tb.sv
